/* src/idf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the integer decimal formatter.
// No dependencies; used by idf_dabble_stage and integer_decimal_formatter_top.
package idf_pkg;

  localparam int VALUE_W = 64;
  localparam int DIGITS = 20;
  localparam int BCD_W = DIGITS * 4;
  localparam int DAB_STAGES = 8;
  localparam int DAB_STEPS = VALUE_W / DAB_STAGES;

  localparam logic [1:0] SIZE_DEFAULT = 2'd0;
  localparam logic [1:0] SIZE_SHORT = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;
  localparam logic [1:0] SIZE_UNUSED = 2'd3;

  localparam logic [6:0] CH_ZERO = 7'h30;
  localparam logic [6:0] CH_PLUS = 7'h2B;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  typedef struct packed {
    logic        func;
    logic [63:0] value;
    logic [1:0]  size_mode;
    logic        plus_flag;
    logic        space_flag;
    logic        left_justify;
    logic [5:0]  field_width;
    logic [5:0]  digit_precision;
  } item_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } text_t;

  // Per-item attributes that ride along with the conversion.
  typedef struct packed {
    logic       sign_en;
    logic [6:0] sign_ch;
    logic       left;
    logic [5:0] width;
    logic [5:0] prec;
  } meta_t;

  typedef struct packed {
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
    meta_t              meta;
  } dab_t;

endpackage

/* src/idf_dabble_stage.sv */
`timescale 1ns / 1ps
// One registered slice of the binary-to-BCD shift-and-add-3 converter.
// Depends on idf_pkg for dab_t and step counts.
module idf_dabble_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  idf_pkg::dab_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output idf_pkg::dab_t dn_data
);

  idf_pkg::dab_t data_next;

  always_comb begin
    logic [idf_pkg::BCD_W-1:0]   bcd;
    logic [idf_pkg::VALUE_W-1:0] bin;
    bcd = up_data.bcd;
    bin = up_data.bin;
    for (int s = 0; s < idf_pkg::DAB_STEPS; s++) begin
      for (int d = 0; d < idf_pkg::DIGITS; d++) begin
        if (bcd[d*4 +: 4] >= 4'd5) begin
          bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
        end
      end
      bcd = {bcd[idf_pkg::BCD_W-2:0], bin[idf_pkg::VALUE_W-1]};
      bin = {bin[idf_pkg::VALUE_W-2:0], 1'b0};
    end
    data_next.bcd = bcd;
    data_next.bin = bin;
    data_next.meta = up_data.meta;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

/* src/integer_decimal_formatter_top.sv */
`timescale 1ns / 1ps
// Top level of the integer decimal formatter: input register, sign/size stage,
// eight BCD stages, layout stage and character serializer. Uses idf_pkg, idf_dabble_stage.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes one conversion per
//   transaction: value, signed/unsigned, size, flags, width and precision.
//   text channel (text_valid/text_ready/text) returns the formatted text,
//   one ASCII character per transaction, last set on the final one.
//   The first character of an item is offered once the item has passed the input
//   register, the 8 BCD stages, the layout stage and the serializer.
//   Throughput: an item yields 1 to MAX_FIELD + 1 characters; the serializer
//   emits one character per cycle while text_ready is high and takes the
//   next item as its last character is taken, while up to ten later items fill the pipeline.
//   Reset (synchronous, active high) clears every valid bit; items in flight
//   are dropped. When the receiver holds text_ready low the serializer holds
//   its character, and each stage holds once the stage after it is full,
//   so nothing is lost or repeated.
//   Width and precision above MAX_FIELD saturate to MAX_FIELD.
module integer_decimal_formatter_top #(
  parameter int MAX_FIELD = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  idf_pkg::item_t item,
  output logic           text_valid,
  input  logic           text_ready,
  output idf_pkg::text_t text
);

  localparam logic [5:0] MAX_F = 6'(MAX_FIELD);

  // ---------------------------------------------------------------- input register
  logic           in_v;
  idf_pkg::item_t in_q;
  logic           in_adv;

  // ---------------------------------------------------------------- sign and size
  idf_pkg::dab_t head;

  always_comb begin
    logic [63:0] mag;
    logic        neg;
    mag = {32'd0, in_q.value[31:0]};
    neg = !in_q.func && in_q.value[31];
    if (in_q.size_mode == idf_pkg::SIZE_SHORT) begin
      mag = {48'd0, in_q.value[15:0]};
      neg = !in_q.func && in_q.value[15];
    end else if (in_q.size_mode == idf_pkg::SIZE_LONG) begin
      mag = in_q.value;
      neg = !in_q.func && in_q.value[63];
    end
    // Two's complement negate; the most negative value wraps to its own magnitude.
    if (neg) begin
      mag = 64'd0 - mag;
    end
    if (in_q.size_mode == idf_pkg::SIZE_SHORT) begin
      mag = {48'd0, mag[15:0]};
    end else if (in_q.size_mode != idf_pkg::SIZE_LONG) begin
      mag = {32'd0, mag[31:0]};
    end
    head.bin = mag;
    head.bcd = '0;
    head.meta.sign_en = neg || in_q.plus_flag || in_q.space_flag;
    head.meta.sign_ch = neg ? idf_pkg::CH_MINUS :
                        (in_q.plus_flag ? idf_pkg::CH_PLUS : idf_pkg::CH_SPACE);
    head.meta.left = in_q.left_justify;
    head.meta.width = (in_q.field_width > MAX_F) ? MAX_F : in_q.field_width;
    head.meta.prec = (in_q.digit_precision > MAX_F) ? MAX_F : in_q.digit_precision;
  end

  // ---------------------------------------------------------------- BCD pipeline
  logic          dab_valid [idf_pkg::DAB_STAGES+1];
  logic          dab_ready [idf_pkg::DAB_STAGES+1];
  idf_pkg::dab_t dab_data  [idf_pkg::DAB_STAGES+1];

  assign dab_valid[0] = in_v;
  assign dab_data[0] = head;
  assign in_adv = dab_ready[0];
  assign item_ready = !in_v || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (item_ready) begin
      in_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_q <= item;
    end
  end

  for (genvar g = 0; g < idf_pkg::DAB_STAGES; g++) begin : g_dab
    idf_dabble_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (dab_valid[g]),
      .up_ready (dab_ready[g]),
      .up_data  (dab_data[g]),
      .dn_valid (dab_valid[g+1]),
      .dn_ready (dab_ready[g+1]),
      .dn_data  (dab_data[g+1])
    );
  end

  // ---------------------------------------------------------------- layout stage
  // Work out digit count, zero fill, leading pad and total length.
  logic                     lay_v;
  logic                     lay_ready;
  logic [idf_pkg::BCD_W-1:0] lay_bcd;
  logic                     lay_sign_en;
  logic [6:0]               lay_sign_ch;
  logic [5:0]               lay_lead;
  logic [5:0]               lay_zeros;
  logic [4:0]               lay_ndig;
  logic [5:0]               lay_last;

  logic [4:0] ndig_next;
  logic [5:0] zeros_next;
  logic [5:0] lead_next;
  logic [5:0] last_next;

  always_comb begin
    idf_pkg::dab_t t;
    logic [5:0] body;
    logic [5:0] pad;
    logic [5:0] total;
    t = dab_data[idf_pkg::DAB_STAGES];
    ndig_next = 5'd1;
    for (int d = 0; d < idf_pkg::DIGITS; d++) begin
      if (t.bcd[d*4 +: 4] != 4'd0) begin
        ndig_next = 5'(d + 1);
      end
    end
    zeros_next = (t.meta.prec > {1'b0, ndig_next}) ? t.meta.prec - {1'b0, ndig_next} : 6'd0;
    body = {5'd0, t.meta.sign_en} + zeros_next + {1'b0, ndig_next};
    pad = (t.meta.width > body) ? t.meta.width - body : 6'd0;
    total = body + pad;
    lead_next = t.meta.left ? 6'd0 : pad;
    last_next = total - 6'd1;
  end

  assign dab_ready[idf_pkg::DAB_STAGES] = !lay_v || lay_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lay_v <= 1'b0;
    end else if (dab_ready[idf_pkg::DAB_STAGES]) begin
      lay_v <= dab_valid[idf_pkg::DAB_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (dab_ready[idf_pkg::DAB_STAGES] && dab_valid[idf_pkg::DAB_STAGES]) begin
      lay_bcd <= dab_data[idf_pkg::DAB_STAGES].bcd;
      lay_sign_en <= dab_data[idf_pkg::DAB_STAGES].meta.sign_en;
      lay_sign_ch <= dab_data[idf_pkg::DAB_STAGES].meta.sign_ch;
      lay_lead <= lead_next;
      lay_zeros <= zeros_next;
      lay_ndig <= ndig_next;
      lay_last <= last_next;
    end
  end

  // ---------------------------------------------------------------- serializer
  // Walk a character index across pad, sign, zero fill, digits, pad.
  logic                      ser_v;
  logic [idf_pkg::BCD_W-1:0] ser_bcd;
  logic                      ser_sign_en;
  logic [6:0]                ser_sign_ch;
  logic [5:0]                ser_lead;
  logic [5:0]                ser_zeros;
  logic [4:0]                ser_ndig;
  logic [5:0]                ser_last;
  logic [5:0]                ser_idx;
  logic                      ser_done;

  assign ser_done = text_ready && (ser_idx == ser_last);
  assign lay_ready = !ser_v || ser_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v <= 1'b0;
      ser_idx <= 6'd0;
    end else if (lay_ready) begin
      ser_v <= lay_v;
      ser_idx <= 6'd0;
    end else if (text_ready) begin
      ser_idx <= ser_idx + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (lay_ready && lay_v) begin
      ser_bcd <= lay_bcd;
      ser_sign_en <= lay_sign_en;
      ser_sign_ch <= lay_sign_ch;
      ser_lead <= lay_lead;
      ser_zeros <= lay_zeros;
      ser_ndig <= lay_ndig;
      ser_last <= lay_last;
    end
  end

  always_comb begin
    logic [5:0] j;
    logic [5:0] k;
    logic [5:0] d;
    logic [4:0] pos;
    j = ser_idx - ser_lead;
    k = j - {5'd0, ser_sign_en};
    d = k - ser_zeros;
    pos = ser_ndig - 5'd1 - d[4:0];
    if (ser_idx < ser_lead) begin
      text.character = idf_pkg::CH_SPACE;
    end else if (ser_sign_en && j == 6'd0) begin
      text.character = ser_sign_ch;
    end else if (k < ser_zeros) begin
      text.character = idf_pkg::CH_ZERO;
    end else if (d < {1'b0, ser_ndig}) begin
      text.character = idf_pkg::CH_ZERO + {3'd0, ser_bcd[pos*4 +: 4]};
    end else begin
      text.character = idf_pkg::CH_SPACE;
    end
    text.last = (ser_idx == ser_last);
  end

  assign text_valid = ser_v;

endmodule

/* bench/integer_decimal_formatter_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for integer_decimal_formatter_top: directed and random conversions,
// predicted text checked character by character. Depends on idf_pkg and the RTL.
module integer_decimal_formatter_top_tb;

  localparam int MAX_FIELD = 32;
  localparam int CYCLE_LIMIT = 3000000;

  // Expected text per accepted conversion, compared as characters stream out.
  class text_scoreboard;
    idf_pkg::text_t pending_chars[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Predict the printf text for one accepted conversion.
    function void note_item(idf_pkg::item_t it);
      logic [63:0] mag;
      logic neg;
      logic [6:0] sign_ch;
      logic has_sign;
      logic [6:0] digs[$];
      logic [6:0] line[$];
      int width, prec, zeros, pad, body;
      neg = 1'b0;
      width = (it.field_width > MAX_FIELD) ? MAX_FIELD : it.field_width;
      prec = (it.digit_precision > MAX_FIELD) ? MAX_FIELD : it.digit_precision;
      case (it.size_mode)
        idf_pkg::SIZE_SHORT: begin
          mag = {48'd0, it.value[15:0]};
          if (!it.func && mag[15]) begin
            neg = 1'b1;
            mag = {48'd0, 16'd0 - mag[15:0]};
          end
        end
        idf_pkg::SIZE_LONG: begin
          mag = it.value;
          if (!it.func && mag[63]) begin
            neg = 1'b1;
            mag = 64'd0 - mag;
          end
        end
        default: begin
          mag = {32'd0, it.value[31:0]};
          if (!it.func && mag[31]) begin
            neg = 1'b1;
            mag = {32'd0, 32'd0 - mag[31:0]};
          end
        end
      endcase
      do begin
        digs.push_front(idf_pkg::CH_ZERO + 7'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      zeros = (prec > digs.size()) ? prec - digs.size() : 0;
      has_sign = 1'b1;
      if (neg) sign_ch = idf_pkg::CH_MINUS;
      else if (it.plus_flag) sign_ch = idf_pkg::CH_PLUS;
      else if (it.space_flag) sign_ch = idf_pkg::CH_SPACE;
      else has_sign = 1'b0;
      body = int'(has_sign) + zeros + digs.size();
      pad = (width > body) ? width - body : 0;
      if (!it.left_justify) repeat (pad) line.push_back(idf_pkg::CH_SPACE);
      if (has_sign) line.push_back(sign_ch);
      repeat (zeros) line.push_back(idf_pkg::CH_ZERO);
      foreach (digs[i]) line.push_back(digs[i]);
      if (it.left_justify) repeat (pad) line.push_back(idf_pkg::CH_SPACE);
      foreach (line[i]) pending_chars.push_back('{line[i], i == line.size() - 1});
    endfunction

    // Compare one received character with the oldest prediction.
    function void check_char(idf_pkg::text_t got);
      idf_pkg::text_t exp_t;
      if (pending_chars.size() == 0) begin
        $error("unexpected character %h", got.character);
        errors++;
        return;
      end
      exp_t = pending_chars.pop_front();
      if (got.character !== exp_t.character) begin
        $error("character: expected %h actual %h", exp_t.character, got.character);
        errors++;
      end
      if (got.last !== exp_t.last) begin
        $error("last: expected %b actual %b", exp_t.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic item_valid, item_ready, text_valid, text_ready;
  idf_pkg::item_t item;
  idf_pkg::text_t text;
  text_scoreboard sb;
  int cycles;
  int hold_off;
  bit stim_done;

  integer_decimal_formatter_top #(.MAX_FIELD(MAX_FIELD)) u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .text_valid(text_valid), .text_ready(text_ready), .text(text)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Offer one conversion and hold it until the transaction completes.
  task automatic send_item(idf_pkg::item_t it);
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    sb.note_item(it);
  endtask

  // Send a conversion, then drop valid for a random gap (valid stays up on zero gap).
  task automatic offer(idf_pkg::item_t it);
    int g;
    send_item(it);
    g = gap_len();
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic idf_pkg::item_t random_item();
    idf_pkg::item_t it;
    it.func = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: it.value = {$urandom, $urandom};
      1: it.value = 64'($urandom_range(0, 999));
      2: it.value = ~64'($urandom_range(0, 999));
      default: it.value = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    it.size_mode = 2'($urandom_range(0, 3));
    it.plus_flag = 1'($urandom_range(0, 1));
    it.space_flag = 1'($urandom_range(0, 1));
    it.left_justify = 1'($urandom_range(0, 1));
    // Keep most widths and precisions inside the field limit, a few above it.
    it.field_width = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 24));
    it.digit_precision = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 22));
    return it;
  endfunction

  // Directed conversions: extremes, sizes, flags, zero, saturation.
  task automatic run_directed();
    idf_pkg::item_t it;
    it = '0;
    offer(it);                                   // zero, precision zero
    it.func = 1'b0; it.size_mode = idf_pkg::SIZE_LONG;
    it.value = 64'h8000_0000_0000_0000; offer(it);  // most negative long
    it.value = 64'h7FFF_FFFF_FFFF_FFFF; it.plus_flag = 1'b1; offer(it);
    it.func = 1'b1; it.value = '1; it.plus_flag = 1'b0; it.space_flag = 1'b1;
    offer(it);                                   // unsigned max long with space
    it.size_mode = idf_pkg::SIZE_SHORT; it.value = 64'hFFFF_FFFF_FFFF_8000; offer(it);
    it.func = 1'b0; offer(it);                   // short -32768
    it.size_mode = idf_pkg::SIZE_DEFAULT; it.value = 64'h1234_5678_8000_0000; offer(it);
    it.size_mode = idf_pkg::SIZE_UNUSED; it.func = 1'b1; it.plus_flag = 1'b1; offer(it);
    it = '0; it.value = 64'd42; it.field_width = 6'd10; offer(it);
    it.left_justify = 1'b1; offer(it);
    it.digit_precision = 6'd8; it.plus_flag = 1'b1; offer(it);
    it.field_width = 6'd63; it.digit_precision = 6'd63; offer(it);  // saturation
    it.left_justify = 1'b0; it.value = '1; it.size_mode = idf_pkg::SIZE_LONG; offer(it);
    it = '0; it.digit_precision = 6'd5; it.space_flag = 1'b1; offer(it);
    it.field_width = 6'd32; it.value = 64'd7; it.func = 1'b1; offer(it);
  endtask

  // Sender: reset, directed, random, with a long receiver hold-off in the middle.
  initial begin
    sb = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    stim_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int n = 0; n < 455; n++) begin
      if (n == 150) hold_off = 300;   // let the pipeline fill and back up
      offer(random_item());
    end
    item_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus the long hold-off counted here.
  initial begin
    int g;
    g = 0;
    text_ready = 1'b0;
    hold_off = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        text_ready <= 1'b0;
      end else if (g > 0) begin
        g--;
        text_ready <= 1'b0;
      end else begin
        text_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) g = gap_len();
      end
    end
  end

  // Check each character transaction as it completes.
  always @(posedge clk) begin
    if (!rst && text_valid && text_ready) sb.check_char(text);
  end

  // Wait for the drain, then report; the cycle counter guards against hangs.
  initial begin
    cycles = 0;
    while (!(stim_done && sb.pending_chars.size() == 0)) begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
